// ----- design/xrng_pkg.sv -----
// Package: shared types, constants and command codes for the xoshiro256** generator.
`default_nettype none

package xrng_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned HALF_W = WORD_W / 2;
   localparam int unsigned MODE_W = 3;

   localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;
   localparam logic [WORD_W-1:0] PRINT_BASE = 64'd32;
   localparam logic [WORD_W-1:0] PRINT_SPAN = 64'd95;
   localparam logic [WORD_W-1:0] INT_MIN_PAT = 64'h8000_0000_0000_0000;
   localparam logic [WORD_W-1:0] INT_MAX_PAT = 64'h7fff_ffff_ffff_ffff;
   localparam logic [3:0] UUID_VERSION = 4'h4;
   localparam logic [1:0] UUID_VARIANT = 2'b10;

   localparam int unsigned SEED_WORDS = 4;
   localparam int unsigned IDX_W      = $clog2(SEED_WORDS);
   localparam int unsigned DIV_STEPS  = WORD_W;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int unsigned MUL_PHASES = 4;
   localparam int unsigned PHASE_W    = $clog2(MUL_PHASES);

   localparam logic [MODE_W-1:0] MODE_RAW   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RANGE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BOOL  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PRINT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MANT  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_UUID  = 3'd5;

   localparam logic [PHASE_W-1:0] PH_LL  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_LH  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_HL  = 2'd2;
   localparam logic [PHASE_W-1:0] PH_SUM = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [WORD_W-1:0] range_min;
      logic signed [WORD_W-1:0] range_max;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              last;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NONE      = 4'd0,
      DP_CAPTURE   = 4'd1,
      DP_SEED_LOAD = 4'd2,
      DP_MIX_ADD   = 4'd3,
      DP_MUL       = 4'd4,
      DP_DRAW      = 4'd5,
      DP_DRAW_FIN  = 4'd6,
      DP_DIV_LOAD  = 4'd7,
      DP_DIV_STEP  = 4'd8,
      DP_EMIT      = 4'd9
   } dp_op_type;

   typedef enum logic [2:0] {
      RES_RAW   = 3'd0,
      RES_MIN   = 3'd1,
      RES_RANGE = 3'd2,
      RES_BOOL  = 3'd3,
      RES_CHAR  = 3'd4,
      RES_MANT  = 3'd5,
      RES_UUID0 = 3'd6,
      RES_UUID1 = 3'd7
   } res_sel_type;

   typedef struct packed {
      dp_op_type          op;
      logic [PHASE_W-1:0] mul_phase;
      logic               mul_k_b;
      res_sel_type        res_sel;
      logic               res_last;
      logic               div_by_span;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              empty;
      logic              span_zero;
      logic              seed_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- design/xrng_dp.sv -----
// Datapath: state words, seed expansion, output draw, remainder divider and result register.
`default_nettype none

module xrng_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  xrng_pkg::dp_cmd_type  cmd,
   output xrng_pkg::dp_status_type status,
   input  xrng_pkg::req_type     req_data,
   input  logic                  csr_wr_en,
   input  logic [63:0]           csr_wr_data,
   output xrng_pkg::rsp_type     rsp_data
);
   import xrng_pkg::*;

   logic [WORD_W-1:0] seed_ff, seed_in;
   logic [WORD_W-1:0] gen_ff [SEED_WORDS];
   logic [WORD_W-1:0] gen_in [SEED_WORDS];
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] z_ff, z_in;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [WORD_W-1:0] r_ff, r_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] dvd_ff, dvd_in;
   logic [WORD_W-1:0] dsr_ff, dsr_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [WORD_W-1:0] min_ff, min_in;
   logic [WORD_W-1:0] span_ff, span_in;
   logic              empty_ff, empty_in;
   logic              span_zero_ff, span_zero_in;
   rsp_type           rsp_ff, rsp_in;

   logic [WORD_W-1:0] mul_k;
   logic [HALF_W-1:0] mul_a32, mul_b32;
   logic [WORD_W-1:0] mul_full;
   logic [WORD_W-1:0] mul_fin;
   logic [WORD_W-1:0] mix_sum;
   logic [WORD_W-1:0] res5;
   logic [WORD_W:0]   div_trial, div_diff;
   logic [WORD_W-1:0] out_value;

   assign mul_k    = cmd.mul_k_b ? MIX_MUL_B : MIX_MUL_A;
   assign mul_a32  = (cmd.mul_phase == PH_HL) ? z_ff[WORD_W-1:HALF_W] : z_ff[HALF_W-1:0];
   assign mul_b32  = (cmd.mul_phase == PH_LH) ? mul_k[WORD_W-1:HALF_W] : mul_k[HALF_W-1:0];
   assign mul_full = mul_a32 * mul_b32;
   assign mul_fin  = sum_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
   assign mix_sum  = acc_ff + GOLDEN_INC;
   assign res5     = gen_ff[1] + {gen_ff[1][WORD_W-3:0], 2'b00};
   assign div_trial = {rem_ff, dvd_ff[WORD_W-1]};
   assign div_diff  = div_trial - {1'b0, dsr_ff};

   always_comb begin
      case (cmd.res_sel)
         RES_MIN:   out_value = min_ff;
         RES_RANGE: out_value = min_ff + rem_ff;
         RES_BOOL:  out_value = {{(WORD_W-1){1'b0}}, r_ff[0]};
         RES_CHAR:  out_value = PRINT_BASE + rem_ff;
         RES_MANT:  out_value = {11'd0, r_ff[WORD_W-1:11]};
         RES_UUID0: out_value = {r_ff[63:56], UUID_VERSION, r_ff[51:0]};
         RES_UUID1: out_value = {r_ff[63:8], UUID_VARIANT, r_ff[5:0]};
         default:   out_value = r_ff;
      endcase
   end

   always_comb begin
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      gen_in       = gen_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      z_in         = z_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      r_in         = r_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      dsr_in       = dsr_ff;
      mode_in      = mode_ff;
      min_in       = min_ff;
      span_in      = span_ff;
      empty_in     = empty_ff;
      span_zero_in = span_zero_ff;
      rsp_in       = rsp_ff;
      case (cmd.op)
         DP_CAPTURE: begin
            mode_in      = req_data.mode;
            min_in       = req_data.range_min;
            span_in      = req_data.range_max - req_data.range_min + 64'd1;
            empty_in     = (req_data.range_min >= req_data.range_max);
            span_zero_in = (req_data.range_min == INT_MIN_PAT)
                           && (req_data.range_max == INT_MAX_PAT);
         end
         DP_SEED_LOAD: begin
            acc_in = seed_ff;
            idx_in = '0;
         end
         DP_MIX_ADD: begin
            acc_in = mix_sum;
            z_in   = mix_sum ^ (mix_sum >> 30);
         end
         DP_MUL: begin
            prod_in = mul_full;
            case (cmd.mul_phase)
               PH_LH: sum_in = prod_ff;
               PH_HL: sum_in = mul_fin;
               PH_SUM: begin
                  if (cmd.mul_k_b) begin
                     gen_in[idx_ff] = mul_fin ^ (mul_fin >> 31);
                     idx_in         = idx_ff + 1'b1;
                  end else begin
                     z_in = mul_fin ^ (mul_fin >> 27);
                  end
               end
               default: sum_in = sum_ff;
            endcase
         end
         DP_DRAW: begin
            r_in      = {res5[WORD_W-8:0], res5[WORD_W-1:WORD_W-7]};
            gen_in[0] = gen_ff[0] ^ gen_ff[3] ^ gen_ff[1];
            gen_in[1] = gen_ff[1] ^ gen_ff[2] ^ gen_ff[0];
            gen_in[2] = gen_ff[2] ^ gen_ff[0] ^ {gen_ff[1][WORD_W-18:0], 17'd0};
            gen_in[3] = {gen_ff[3][18:0] ^ gen_ff[1][18:0],
                         gen_ff[3][WORD_W-1:19] ^ gen_ff[1][WORD_W-1:19]};
         end
         DP_DRAW_FIN: begin
            r_in = r_ff + {r_ff[WORD_W-4:0], 3'b000};
         end
         DP_DIV_LOAD: begin
            rem_in = '0;
            dvd_in = r_ff;
            dsr_in = cmd.div_by_span ? span_ff : PRINT_SPAN;
         end
         DP_DIV_STEP: begin
            rem_in = div_diff[WORD_W] ? div_trial[WORD_W-1:0] : div_diff[WORD_W-1:0];
            dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
         end
         DP_EMIT: begin
            rsp_in.value = out_value;
            rsp_in.last  = cmd.res_last;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      gen_ff       <= gen_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      z_ff         <= z_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      r_ff         <= r_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      dsr_ff       <= dsr_in;
      mode_ff      <= mode_in;
      min_ff       <= min_in;
      span_ff      <= span_in;
      empty_ff     <= empty_in;
      span_zero_ff <= span_zero_in;
      rsp_ff       <= rsp_in;
   end

   assign status.mode      = mode_ff;
   assign status.empty     = empty_ff;
   assign status.span_zero = span_zero_ff;
   assign status.seed_last = (idx_ff == IDX_W'(SEED_WORDS - 1));
   assign rsp_data         = rsp_ff;

endmodule

`default_nettype wire

// ----- design/xrng_ctrl.sv -----
// Controller: state machine that sequences seeding, drawing, division and result hand-off.
`default_nettype none

module xrng_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    csr_wr_en,
   input  xrng_pkg::dp_status_type status,
   output xrng_pkg::dp_cmd_type    cmd
);
   import xrng_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_DISPATCH  = 10'b00_0000_0010,
      S_SEED_LOAD = 10'b00_0000_0100,
      S_MIX_ADD   = 10'b00_0000_1000,
      S_MUL       = 10'b00_0001_0000,
      S_DRAW      = 10'b00_0010_0000,
      S_DRAW_FIN  = 10'b00_0100_0000,
      S_DIV_LOAD  = 10'b00_1000_0000,
      S_DIV       = 10'b01_0000_0000,
      S_EMIT      = 10'b10_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic                 seeded_ff, seeded_in;
   logic                 uuid_second_ff, uuid_second_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic                 pass_b_ff, pass_b_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 uuid_first;
   res_sel_type          res_sel;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign uuid_first = (status.mode == MODE_UUID) && !uuid_second_ff;

   always_comb begin
      case (status.mode)
         MODE_RANGE: begin
            if (status.empty) begin
               res_sel = RES_MIN;
            end else if (status.span_zero) begin
               res_sel = RES_RAW;
            end else begin
               res_sel = RES_RANGE;
            end
         end
         MODE_BOOL:  res_sel = RES_BOOL;
         MODE_PRINT: res_sel = RES_CHAR;
         MODE_MANT:  res_sel = RES_MANT;
         MODE_UUID:  res_sel = uuid_second_ff ? RES_UUID1 : RES_UUID0;
         default:    res_sel = RES_RAW;
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      seeded_in        = seeded_ff;
      uuid_second_in   = uuid_second_ff;
      phase_in         = phase_ff;
      pass_b_in        = pass_b_ff;
      div_cnt_in       = div_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      req_ready        = 1'b0;
      cmd.op           = DP_NONE;
      cmd.mul_phase    = phase_ff;
      cmd.mul_k_b      = pass_b_ff;
      cmd.res_sel      = res_sel;
      cmd.res_last     = !uuid_first;
      cmd.div_by_span  = (status.mode == MODE_RANGE);
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if ((status.mode == MODE_RANGE) && status.empty) begin
               state_in = S_EMIT;
            end else if (!seeded_ff) begin
               state_in = S_SEED_LOAD;
            end else begin
               state_in = S_DRAW;
            end
         end
         S_SEED_LOAD: begin
            cmd.op   = DP_SEED_LOAD;
            state_in = S_MIX_ADD;
         end
         S_MIX_ADD: begin
            cmd.op    = DP_MIX_ADD;
            phase_in  = PH_LL;
            pass_b_in = 1'b0;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.op = DP_MUL;
            if (phase_ff == PH_SUM) begin
               phase_in = PH_LL;
               if (!pass_b_ff) begin
                  pass_b_in = 1'b1;
               end else if (status.seed_last) begin
                  seeded_in = 1'b1;
                  state_in  = S_DRAW;
               end else begin
                  state_in = S_MIX_ADD;
               end
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         S_DRAW: begin
            cmd.op   = DP_DRAW;
            state_in = S_DRAW_FIN;
         end
         S_DRAW_FIN: begin
            cmd.op = DP_DRAW_FIN;
            if (((status.mode == MODE_RANGE) && !status.span_zero)
                || (status.mode == MODE_PRINT)) begin
               state_in = S_DIV_LOAD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_DIV_LOAD: begin
            cmd.op     = DP_DIV_LOAD;
            div_cnt_in = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.op = DP_DIV_STEP;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_EMIT;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.op       = DP_EMIT;
               rsp_valid_in = 1'b1;
               if (uuid_first) begin
                  uuid_second_in = 1'b1;
                  state_in       = S_DRAW;
               end else begin
                  uuid_second_in = 1'b0;
                  state_in       = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (csr_wr_en) begin
         seeded_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         seeded_ff      <= 1'b0;
         uuid_second_ff <= 1'b0;
         phase_ff       <= PH_LL;
         pass_b_ff      <= 1'b0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seeded_ff      <= seeded_in;
         uuid_second_ff <= uuid_second_in;
         phase_ff       <= phase_in;
         pass_b_ff      <= pass_b_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- design/xoshiro256ss_random_generator.sv -----
// Top level of the xoshiro256** random generator with splitmix64 seeding.
//
// An item on the req channel selects a mode (raw word, signed range, bool, printable
// character, 53-bit mantissa or UUIDv4) and carries the range bounds. Each item gives
// one rsp item with last set, except UUID, which gives two, the first with last clear.
// The seed register is written through csr_wr_en and csr_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce. The first
// drawing item after reset or after a seed write first expands the seed into the four
// state words: a step to load the seed, then for each word an add and eight steps of a
// shared 32x32 multiplier. The block takes one item at a time; raw, bool, mantissa and
// full-span range items pass from accept through dispatch, draw and draw finish to the
// output, and range and printable items also pass through the 64-step bit-serial
// remainder divider. A UUID item draws again after its first word to give its second.
// An empty range (min not below max) returns min without drawing. The result sits in an
// output register; a stalled receiver holds the block until that register is free.
// Reset clears the seed to zero and marks the state as not seeded.
`default_nettype none

module xoshiro256ss_random_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xrng_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xrng_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [63:0]       csr_wr_data
);
   import xrng_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   xrng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_wr_en (csr_wr_en),
      .status    (status),
      .cmd       (cmd)
   );

   xrng_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Block took a new item in the cycle after accepting one.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> status.mode == MODE_UUID)
      else $error("A result without last came from an item that is not a UUID item.");

endmodule

`default_nettype wire

// ----- verif/xoshiro256ss_random_generator_test.sv -----
// Self-checking testbench for the xoshiro256** generator with a draw-predicting scoreboard.
module xoshiro256ss_random_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import xrng_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
   localparam int CYCLE_LIMIT      = 1000000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 8;
   localparam int DRAIN_CYCLES     = 100;
   localparam int PHASE_ITEMS      = 196;

   class draw_scoreboard;
      logic [WORD_W-1:0] gen_word [SEED_WORDS];
      logic              seeded;
      logic [WORD_W-1:0] seed_value;
      rsp_type           expected_draws [$];
      int                failures;
      int                requests_seen;
      int                results_seen;
      int                mode_count [8];

      function new();
         foreach (gen_word[i]) gen_word[i] = '0;
         seeded = 1'b0;
         seed_value = '0;
         failures = 0;
         requests_seen = 0;
         results_seen = 0;
         foreach (mode_count[i]) mode_count[i] = 0;
      endfunction

      function void load_seed(logic [WORD_W-1:0] value);
         seed_value = value;
         seeded = 1'b0;
      endfunction

      function int pending();
         return expected_draws.size();
      endfunction

      function logic [WORD_W-1:0] next_word();
         logic [WORD_W-1:0] acc;
         logic [WORD_W-1:0] z;
         logic [WORD_W-1:0] res;
         logic [WORD_W-1:0] t;
         if (!seeded) begin
            acc = seed_value;
            for (int i = 0; i < SEED_WORDS; i++) begin
               acc = acc + GOLDEN_INC;
               z = acc;
               z = (z ^ (z >> 30)) * MIX_MUL_A;
               z = (z ^ (z >> 27)) * MIX_MUL_B;
               gen_word[i] = z ^ (z >> 31);
            end
            seeded = 1'b1;
         end
         z = gen_word[1] * 64'd5;
         res = {z[56:0], z[63:57]} * 64'd9;
         t = gen_word[1] << 17;
         gen_word[2] = gen_word[2] ^ gen_word[0];
         gen_word[3] = gen_word[3] ^ gen_word[1];
         gen_word[1] = gen_word[1] ^ gen_word[2];
         gen_word[0] = gen_word[0] ^ gen_word[3];
         gen_word[2] = gen_word[2] ^ t;
         gen_word[3] = {gen_word[3][18:0], gen_word[3][63:19]};
         return res;
      endfunction

      function void note_request(req_type item);
         rsp_type           first;
         rsp_type           second;
         logic [WORD_W-1:0] span;
         logic [WORD_W-1:0] r;
         logic [WORD_W-1:0] lo;
         logic [WORD_W-1:0] hi;
         requests_seen++;
         mode_count[item.mode]++;
         lo = item.range_min;
         hi = item.range_max;
         first.last = 1'b1;
         case (item.mode)
            MODE_RANGE: begin
               if ($signed(lo) >= $signed(hi)) begin
                  first.value = lo;
               end else begin
                  span = hi - lo + 64'd1;
                  r = next_word();
                  first.value = (span == '0) ? r : lo + (r % span);
               end
            end
            MODE_BOOL: begin
               r = next_word();
               first.value = {63'd0, r[0]};
            end
            MODE_PRINT: begin
               r = next_word();
               first.value = PRINT_BASE + (r % PRINT_SPAN);
            end
            MODE_MANT: begin
               r = next_word();
               first.value = r >> 11;
            end
            MODE_UUID: begin
               r = next_word();
               first.value = {r[63:56], UUID_VERSION, r[51:48], r[47:0]};
               first.last = 1'b0;
               r = next_word();
               second.value = {r[63:8], UUID_VARIANT, r[5:0]};
               second.last = 1'b1;
            end
            default: begin
               first.value = next_word();
            end
         endcase
         expected_draws.push_back(first);
         if (item.mode == MODE_UUID) begin
            expected_draws.push_back(second);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         results_seen++;
         if (expected_draws.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, value %h last %b", $time, got.value, got.last);
            return;
         end
         want = expected_draws.pop_front();
         if (got.value !== want.value) begin
            failures++;
            $display("%0t: value mismatch, expected %h actual %h",
                     $time, want.value, got.value);
         end
         if (got.last !== want.last) begin
            failures++;
            $display("%0t: last mismatch, expected %b actual %b", $time, want.last, got.last);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [63:0]       csr_wr_data = '0;

   draw_scoreboard board = new();
   logic sender_idle_on = 1'b0;
   logic receiver_idle_on = 1'b0;
   logic hold_receiver = 1'b0;
   int   cycle_count = 0;
   int   seed_writes = 0;

   xoshiro256ss_random_generator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results pending",
                  cycle_count, board.pending());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_data);
         end
      end
   end

   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_receiver) begin
            stall = LONG_HOLD_CYCLES;
            hold_receiver = 1'b0;
         end else if (receiver_idle_on) begin
            stall = $urandom_range(0, 14);
         end else begin
            stall = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic req_type make_request(logic [MODE_W-1:0] mode,
                                            logic [WORD_W-1:0] lo,
                                            logic [WORD_W-1:0] hi);
      req_type item;
      item.mode = mode;
      item.range_min = lo;
      item.range_max = hi;
      return item;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      case ($urandom_range(0, 9))
         0: return MODE_RAW;
         1, 2: return MODE_RANGE;
         3: return MODE_BOOL;
         4: return MODE_PRINT;
         5: return MODE_MANT;
         6, 7: return MODE_UUID;
         8: return MODE_SPARE_A;
         default: return MODE_SPARE_B;
      endcase
   endfunction

   function automatic req_type random_request();
      logic [MODE_W-1:0] mode;
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
      mode = pick_mode();
      lo = rand_word();
      hi = rand_word();
      if (mode == MODE_RANGE) begin
         case ($urandom_range(0, 5))
            0: ;
            1: begin
               lo = 64'($urandom_range(0, 2000)) - 64'd1000;
               hi = lo + 64'($urandom_range(0, 1000));
            end
            2: begin
               if ($urandom_range(0, 1)) lo = INT_MIN_PAT;
               hi = INT_MAX_PAT;
            end
            3: hi = lo;
            4: begin
               lo = INT_MIN_PAT;
               hi = INT_MIN_PAT + 64'($urandom_range(0, 300));
            end
            default: hi = lo - 64'($urandom_range(1, 5));
         endcase
      end
      return make_request(mode, lo, hi);
   endfunction

   task automatic send(input req_type item);
      int gap;
      gap = sender_idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      board.load_seed(value);
      seed_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_directed();
      send(make_request(MODE_RANGE, 64'd5, 64'd5));
      send(make_request(MODE_RAW, '0, '0));
      send(make_request(MODE_RANGE, INT_MIN_PAT, INT_MAX_PAT));
      send(make_request(MODE_RANGE, INT_MIN_PAT, INT_MIN_PAT + 64'd1));
      send(make_request(MODE_RANGE, INT_MAX_PAT - 64'd1, INT_MAX_PAT));
      send(make_request(MODE_RANGE, INT_MAX_PAT, INT_MIN_PAT));
      send(make_request(MODE_RANGE, '1, INT_MAX_PAT));
      send(make_request(MODE_RANGE, INT_MIN_PAT, '1));
      send(make_request(MODE_RANGE, -64'sd5, 64'sd5));
      send(make_request(MODE_RANGE, '0, 64'd1));
      send(make_request(MODE_RANGE, '1, -64'sd2));
      send(make_request(MODE_BOOL, '1, '1));
      send(make_request(MODE_PRINT, '0, '0));
      send(make_request(MODE_MANT, '0, '0));
      send(make_request(MODE_UUID, '1, '0));
      send(make_request(MODE_SPARE_A, '0, '0));
      send(make_request(MODE_SPARE_B, '1, '1));
      wait_idle();
      write_seed('1);
      send(make_request(MODE_RANGE, INT_MIN_PAT, INT_MIN_PAT));
      send(make_request(MODE_UUID, '0, '0));
      send(make_request(MODE_PRINT, '1, '1));
      send(make_request(MODE_RANGE, INT_MIN_PAT, INT_MAX_PAT));
   endtask

   initial begin
      logic [63:0] phase_seed [6];
      phase_seed[0] = '0;
      phase_seed[1] = rand_word();
      phase_seed[2] = 64'd1;
      phase_seed[3] = rand_word();
      phase_seed[4] = INT_MIN_PAT;
      phase_seed[5] = '1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         write_seed(phase_seed[p]);
         sender_idle_on = p[0];
         receiver_idle_on = p[1];
         if (p == 2) begin
            sender_idle_on = 1'b0;
            hold_receiver = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send(random_request());
         end
      end
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests giving %0d results under %0d seed writes in %0d cycles.",
               board.requests_seen, board.results_seen, seed_writes, cycle_count);
      $display("Requests by mode: raw %0d range %0d bool %0d char %0d mant %0d uuid %0d spare %0d",
               board.mode_count[0], board.mode_count[1], board.mode_count[2],
               board.mode_count[3], board.mode_count[4], board.mode_count[5],
               board.mode_count[6] + board.mode_count[7]);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
